>>> src/sensor_status_moving_average_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor status moving average block
// Concurrent checks on the clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_STATUS_MOVING_AVERAGE_ASSERT_SVH
`define SENSOR_STATUS_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication
`define SSMA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SSMA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ssma_pkg.sv
// ----------------------------------------------------------------------------
// ssma_pkg
// Codes and fixed widths shared by the sensor status moving average block.
// ----------------------------------------------------------------------------
package ssma_pkg;

   // Fixed field widths
   localparam int SENSOR_W = 2;
   localparam int STATUS_W = 2;
   localparam int KELVIN_W = 10;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 2;

   typedef logic [SENSOR_W-1:0] sensor_idx_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [KELVIN_W-1:0] kelvin_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Read status codes
   localparam status_type STATUS_OK             = 2'd0;
   localparam status_type STATUS_NOT_POWERED    = 2'd1;
   localparam status_type STATUS_NOT_CALIBRATED = 2'd2;
   localparam status_type STATUS_ERROR          = 2'd3;

   // Register indexes
   localparam csr_idx_type CSR_MARKER_NOT_POWERED    = 2'd0;
   localparam csr_idx_type CSR_MARKER_NOT_CALIBRATED = 2'd1;
   localparam csr_idx_type CSR_MARKER_ERROR          = 2'd2;

   // Register reset values
   localparam byte_type MARKER_NOT_POWERED_RST    = 8'd253;
   localparam byte_type MARKER_NOT_CALIBRATED_RST = 8'd252;
   localparam byte_type MARKER_ERROR_RST          = 8'd254;

   // Offset from Kelvin to Celsius
   localparam kelvin_type KELVIN_OFFSET = 10'd273;

endpackage

>>> src/sensor_status_moving_average.sv
// ----------------------------------------------------------------------------
// sensor_status_moving_average
// Per-sensor boxcar moving average of temperature status bytes.
// ----------------------------------------------------------------------------
// Each request carries one reading for one sensor. A good reading is stored
// as Celsius (Kelvin minus 273, wrapped to 8 bits), a failed one as the
// marker byte configured for its status. The byte goes into the sensor's
// WINDOW-entry ring at the shared write slot, and the response returns the
// byte and the truncated average of the whole ring (empty entries count as
// zero). A powered-off request clears that sensor's ring and returns zeros.
// The ring store is a single-port-write, single-read memory with a
// registered read; per-entry valid bits give the all-zero reset and the
// clear on power-off at once, so there is no clearing pass after reset.
// A request passes from acceptance to the response register through a
// write state, one memory read per ring entry, a drain state for the last
// read data, a state for the reciprocal multiply that divides by WINDOW,
// and the response load, which waits while a held response is stalled.
// Powered-off and out-of-range requests go straight to the multiply
// state. The next request is accepted from the cycle after the response
// load. A new request is taken while the previous response still waits
// in the output register.
// ----------------------------------------------------------------------------
module sensor_status_moving_average #(
   parameter int SENSORS = 4,
   parameter int WINDOW  = 10
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssma_pkg::sensor_idx_type req_sensor_index,
   input  ssma_pkg::status_type     req_read_status,
   input  ssma_pkg::kelvin_type     req_kelvin,
   input  logic                     req_powered_off,
   input  logic                     req_last_sensor,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ssma_pkg::sensor_idx_type rsp_sensor_out,
   output ssma_pkg::byte_type       rsp_current_byte,
   output ssma_pkg::byte_type       rsp_average_byte,

   input  logic                     csr_write,
   input  ssma_pkg::csr_idx_type    csr_index,
   input  ssma_pkg::byte_type       csr_data
);
   import ssma_pkg::*;

   `include "sensor_status_moving_average_assert.svh"

   localparam int ENTRIES = SENSORS * WINDOW;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int SUM_W   = $clog2(255 * WINDOW + 1);
   localparam int SHIFT   = SUM_W + $clog2(WINDOW);
   localparam int PROD_W  = SUM_W + SHIFT;
   localparam int RECIP   = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
   localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW - 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   sensor_idx_type    sensor_ff;
   byte_type          cur_ff, cur_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_valid_ff;
   byte_type          rd_data_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   byte_type          mark_np_ff, mark_nc_ff, mark_err_ff;
   logic              rsp_valid_ff;
   sensor_idx_type    rsp_sensor_ff;
   byte_type          rsp_cur_ff, rsp_avg_ff;

   logic              req_accept;
   logic              rsp_free;
   logic              in_range;
   logic              mem_we;
   logic [ADDR_W-1:0] rd_addr;
   byte_type          status_byte;
   logic [SUM_W-1:0]  rd_term;

   byte_type          ring_mem [ENTRIES];

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign in_range   = int'(req_sensor_index) < SENSORS;
   assign mem_we     = (state_ff == S_WRITE);
   assign rd_addr    = base_ff + ADDR_W'(cnt_ff);
   assign rd_term    = rd_valid_ff ? SUM_W'(rd_data_ff) : '0;

   // Translate the reading into the byte to store
   always_comb begin
      case (req_read_status)
         STATUS_OK:             status_byte = BYTE_W'(req_kelvin - KELVIN_OFFSET);
         STATUS_NOT_POWERED:    status_byte = mark_np_ff;
         STATUS_NOT_CALIBRATED: status_byte = mark_nc_ff;
         STATUS_ERROR:          status_byte = mark_err_ff;
         default:               status_byte = mark_err_ff;
      endcase
   end

   // Sequence one request through write, ring sweep and divide
   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      base_in    = base_ff;
      wr_addr_in = wr_addr_ff;
      cur_in     = cur_ff;
      sum_in     = sum_ff;
      rd_pend_in = 1'b0;
      valid_in   = valid_ff;

      // Accumulate returning read data
      if (rd_pend_ff) begin
         sum_in = sum_ff + rd_term;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               base_in    = ADDR_W'(int'(req_sensor_index) * WINDOW);
               wr_addr_in = ADDR_W'(int'(req_sensor_index) * WINDOW) + ADDR_W'(slot_ff);
               cnt_in     = '0;
               sum_in     = '0;
               if (req_powered_off) begin
                  // Clear this sensor's row, answer zero
                  cur_in = '0;
                  for (int s = 0; s < SENSORS; s++) begin
                     for (int j = 0; j < WINDOW; j++) begin
                        if (int'(req_sensor_index) == s) begin
                           valid_in[s * WINDOW + j] = 1'b0;
                        end
                     end
                  end
                  state_in = S_MUL;
               end else begin
                  cur_in = status_byte;
                  // Advance the shared slot on the last sensor
                  if (req_last_sensor) begin
                     slot_in = (slot_ff == SLOT_MAX) ? '0 : slot_ff + 1'b1;
                  end
                  state_in = in_range ? S_WRITE : S_MUL;
               end
            end
         end
         S_WRITE: begin
            valid_in[wr_addr_ff] = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            rd_pend_in = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == SLOT_MAX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         slot_ff     <= '0;
         rd_pend_ff  <= 1'b0;
         valid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         mark_np_ff  <= MARKER_NOT_POWERED_RST;
         mark_nc_ff  <= MARKER_NOT_CALIBRATED_RST;
         mark_err_ff <= MARKER_ERROR_RST;
      end else begin
         state_ff   <= state_in;
         slot_ff    <= slot_in;
         rd_pend_ff <= rd_pend_in;
         valid_ff   <= valid_in;
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // Marker registers, unknown indexes dropped
         if (csr_write) begin
            case (csr_index)
               CSR_MARKER_NOT_POWERED:    mark_np_ff  <= csr_data;
               CSR_MARKER_NOT_CALIBRATED: mark_nc_ff  <= csr_data;
               CSR_MARKER_ERROR:          mark_err_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      base_ff     <= base_in;
      wr_addr_ff  <= wr_addr_in;
      cur_ff      <= cur_in;
      sum_ff      <= sum_in;
      rd_valid_ff <= valid_ff[rd_addr];
      // Divide by WINDOW through the reciprocal
      prod_ff     <= PROD_W'(sum_ff) * PROD_W'(RECIP);
      if (req_accept) begin
         sensor_ff <= req_sensor_index;
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_sensor_ff <= sensor_ff;
         rsp_cur_ff    <= cur_ff;
         rsp_avg_ff    <= prod_ff[SHIFT +: BYTE_W];
      end
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_addr_ff] <= cur_ff;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sensor_out   = rsp_sensor_ff;
   assign rsp_current_byte = rsp_cur_ff;
   assign rsp_average_byte = rsp_avg_ff;

   // Checks
   `SSMA_ASSERT_NOW(a_slot_range, 1'b1, slot_ff <= SLOT_MAX, "write slot out of window")
   `SSMA_ASSERT_NEXT(a_slot_hold, !req_accept, $stable(slot_ff), "slot moved without a request")
   `SSMA_ASSERT_NEXT(a_off_zero, req_accept && req_powered_off, state_ff == S_MUL && sum_ff == '0 && cur_ff == '0, "powered-off request not zeroed")
   `SSMA_ASSERT_NEXT(a_done_load, state_ff == S_DONE && rsp_free, rsp_valid_ff && state_ff == S_IDLE, "response not loaded")

endmodule
